[rtl/sasw_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sasw_pkg
// Shared types, constants and elaboration-time helpers for the snow and
// two-layer soil water step pipeline.
// ----------------------------------------------------------------------------
package sasw_pkg;

   // Configuration register indexes
   localparam logic [1:0] CSR_DEFAULT_CAP = 2'd0;
   localparam logic [1:0] CSR_UPPER_CAP   = 2'd1;
   localparam logic [1:0] CSR_RESIST_EXP  = 2'd2;

   localparam logic [19:0] DEFAULT_CAP_RST = 20'd56320;
   localparam logic [19:0] UPPER_CAP_RST   = 20'd5120;
   localparam logic [11:0] RESIST_EXP_RST  = 12'd128;

   // Melt = T*(43008 + 25*P) / 51200, rounded half up; 51200 = 1024 * 50
   localparam int MELT_BASE  = 43008;
   localparam int MELT_GAIN  = 25;
   localparam int MELT_ROUND = 25600;
   localparam int DIV_REST   = 50;
   localparam int RECIP_SHIFT = 34;
   localparam logic [28:0] RECIP_DIV = 29'((64'd1 << RECIP_SHIFT) / DIV_REST);

   // Draw exponent limits
   localparam int K_SAT_MAX  = 20;
   localparam int K_ZERO_MIN = -15;
   localparam int EXP_INT    = 30;

   // Payload delay from the water stage to the draw register
   localparam int DRAW_DLY = 37;
   localparam int DRAW_TAP = 35;

   typedef struct packed {
      logic               wv;
      logic signed [15:0] temp;
      logic [17:0]        precip;
      logic [13:0]        pet;
      logic [23:0]        snow;
      logic [19:0]        up;
      logic [19:0]        low;
      logic [19:0]        total;
   } in_type;

   typedef struct packed {
      logic        wv;
      logic        frozen;
      logic [17:0] precip;
      logic [13:0] pet;
      logic [23:0] snow;
      logic [19:0] up;
      logic [19:0] low;
      logic [19:0] cap0;
      logic [19:0] cap1;
      logic [23:0] snow_acc;
   } cell_type;

   typedef struct packed {
      logic               wv;
      logic               frozen;
      logic               def;
      logic [23:0]        snow_new;
      logic signed [24:0] snow_chg;
      logic [19:0]        up_fin;
      logic [19:0]        low;
      logic [19:0]        low_nd;
      logic [19:0]        cap1;
      logic [13:0]        deficit;
   } pay_type;

   typedef struct packed {
      logic       sat;
      logic       zero;
      logic [5:0] sh;
   } exp_side_type;

   function automatic logic [63:0] sasw_isqrt(input logic [63:0] v);
      logic [63:0] rem;
      logic [63:0] root;
      logic [63:0] bit_v;
      rem   = v;
      root  = '0;
      bit_v = 64'd1 << 62;
      for (int i = 0; i < 32; i++) begin
         if (bit_v > rem) bit_v = bit_v >> 2;
      end
      for (int i = 0; i < 32; i++) begin
         if (bit_v != 64'd0) begin
            if (rem >= root + bit_v) begin
               rem  = rem - (root + bit_v);
               root = (root >> 1) + bit_v;
            end else begin
               root = root >> 1;
            end
            bit_v = bit_v >> 2;
         end
      end
      return root;
   endfunction

   // 2^(2^-idx) in Q30, built by repeated truncated square roots
   function automatic logic [30:0] sasw_root_const(input int idx);
      logic [63:0] c;
      c = 64'd1 << 31;
      for (int i = 1; i <= 16; i++) begin
         if (i <= idx) c = sasw_isqrt(c << 30);
      end
      return c[30:0];
   endfunction

endpackage

[rtl/sasw_log2.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sasw_log2
// Pipelined log2 in Q16: normalize, then sixteen squaring stages.
// ----------------------------------------------------------------------------
module sasw_log2 (
   input  logic        clock,
   input  logic [19:0] n,
   output logic [20:0] lg
);
   import sasw_pkg::*;

   logic [30:0] y_ff [0:16];
   logic [4:0]  e_ff [0:16];
   logic [15:0] fr_ff [0:16];

   logic [4:0] e_in;

   always_comb begin
      e_in = '0;
      for (int b = 0; b < 20; b++) begin
         if (n[b]) e_in = 5'(b);
      end
   end

   always_ff @(posedge clock) begin
      y_ff[0]  <= 31'(n) << (5'd30 - e_in);
      e_ff[0]  <= e_in;
      fr_ff[0] <= '0;
   end

   for (genvar i = 1; i <= 16; i++) begin : g_step
      logic [61:0] sq;
      logic [31:0] t;
      assign sq = 62'(y_ff[i-1]) * 62'(y_ff[i-1]);
      assign t  = sq[61:30];
      always_ff @(posedge clock) begin
         y_ff[i]  <= t[31] ? t[31:1] : t[30:0];
         fr_ff[i] <= {fr_ff[i-1][14:0], t[31]};
         e_ff[i]  <= e_ff[i-1];
      end
   end

   assign lg = {e_ff[16], fr_ff[16]};

endmodule

[rtl/sasw_exp2.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sasw_exp2
// Pipelined 2^(f/65536) in Q30: one conditional root multiply per stage.
// ----------------------------------------------------------------------------
module sasw_exp2 (
   input  logic                   clock,
   input  logic [15:0]            f,
   input  sasw_pkg::exp_side_type side_in,
   output logic [30:0]            m,
   output sasw_pkg::exp_side_type side_out
);
   import sasw_pkg::*;

   logic [30:0]  res_ff [1:16];
   logic [15:0]  f_ff [1:16];
   exp_side_type side_ff [1:16];

   for (genvar i = 1; i <= 16; i++) begin : g_step
      localparam logic [30:0] ROOT = sasw_root_const(i);
      logic [30:0]  res_prev;
      logic [15:0]  f_prev;
      exp_side_type side_prev;
      logic [61:0]  prod;
      if (i == 1) begin : g_first
         assign res_prev  = 31'(1) << EXP_INT;
         assign f_prev    = f;
         assign side_prev = side_in;
      end else begin : g_next
         assign res_prev  = res_ff[i-1];
         assign f_prev    = f_ff[i-1];
         assign side_prev = side_ff[i-1];
      end
      assign prod = 62'(res_prev) * 62'(ROOT);
      always_ff @(posedge clock) begin
         res_ff[i]  <= f_prev[16-i] ? prod[60:30] : res_prev;
         f_ff[i]    <= f_prev;
         side_ff[i] <= side_prev;
      end
   end

   assign m        = res_ff[16];
   assign side_out = side_ff[16];

endmodule

[rtl/snow_and_two_layer_soil_water_step.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// snow_and_two_layer_soil_water_step
// Advances one grid cell by one day: snow pack, upper and lower soil layers.
// ----------------------------------------------------------------------------
// Valid path: s1 to s4, w5, the draw delay line, then the output register.
// Throughput: one beat per cycle; busy stays low.
// The longest stretch is the lower-layer draw: 17 log2 stages, 16 exp2 stages.
// Reset clears every valid bit and loads the register reset values.
// The result channel cannot stall, so no beat is ever held back.
// ----------------------------------------------------------------------------
module snow_and_two_layer_soil_water_step (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic               req_weather_valid,
   input  logic signed [15:0] req_air_temp,
   input  logic [17:0]        req_precip,
   input  logic [13:0]        req_pot_evap,
   input  logic [23:0]        req_snow_in,
   input  logic [19:0]        req_upper_water_in,
   input  logic [19:0]        req_lower_water_in,
   input  logic               req_capacity_valid,
   input  logic [19:0]        req_cell_capacity,
   output logic               rsp_valid,
   output logic               rsp_cell_nodata,
   output logic [23:0]        rsp_snow_out,
   output logic [19:0]        rsp_upper_water_out,
   output logic [19:0]        rsp_lower_water_out,
   output logic signed [24:0] rsp_snow_change,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [1:0]         csr_index,
   input  logic [19:0]        csr_wdata
);
   import sasw_pkg::*;

   // ---------------------------------------------------------------------
   // Config regs, always ready; user must write only while idle, unchecked
   // ---------------------------------------------------------------------
   logic [19:0] dcap_ff;
   logic [19:0] ucap_ff;
   logic [11:0] rexp_ff;

   assign csr_ready = 1'b1;
   assign busy      = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         dcap_ff <= DEFAULT_CAP_RST;
         ucap_ff <= UPPER_CAP_RST;
         rexp_ff <= RESIST_EXP_RST;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_DEFAULT_CAP: dcap_ff <= csr_wdata;
            CSR_UPPER_CAP:   ucap_ff <= csr_wdata;
            CSR_RESIST_EXP:  rexp_ff <= csr_wdata[11:0];
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // Valid bits; the pipeline advances every cycle
   // ---------------------------------------------------------------------
   logic                s1_vld_ff, s2_vld_ff, s3_vld_ff, s4_vld_ff, w5_vld_ff;
   logic [DRAW_DLY:1]   dl_vld_ff;
   logic                out_vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff  <= 1'b0;
         s2_vld_ff  <= 1'b0;
         s3_vld_ff  <= 1'b0;
         s4_vld_ff  <= 1'b0;
         w5_vld_ff  <= 1'b0;
         dl_vld_ff  <= '0;
         out_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff  <= start && !busy;
         s2_vld_ff  <= s1_vld_ff;
         s3_vld_ff  <= s2_vld_ff;
         s4_vld_ff  <= s3_vld_ff;
         w5_vld_ff  <= s4_vld_ff;
         dl_vld_ff  <= {dl_vld_ff[DRAW_DLY-1:1], w5_vld_ff};
         out_vld_ff <= dl_vld_ff[DRAW_DLY];
      end
   end

   // ---------------------------------------------------------------------
   // Stage 1: capture the beat
   // ---------------------------------------------------------------------
   in_type s1_ff;

   always_ff @(posedge clock) begin
      s1_ff.wv     <= req_weather_valid;
      s1_ff.temp   <= req_air_temp;
      s1_ff.precip <= req_precip;
      s1_ff.pet    <= req_pot_evap;
      s1_ff.snow   <= req_snow_in;
      s1_ff.up     <= req_upper_water_in;
      s1_ff.low    <= req_lower_water_in;
      s1_ff.total  <= req_capacity_valid ? req_cell_capacity : dcap_ff;
   end

   // ---------------------------------------------------------------------
   // Stage 2: capacities, snow accumulation, melt product
   // ---------------------------------------------------------------------
   cell_type    c2_in, c2_ff, c3_ff, c4_ff;
   logic [37:0] prod_in, prod_ff;
   logic [22:0] melt_fac;
   logic [24:0] snow_sum;

   always_comb begin
      snow_sum       = {1'b0, s1_ff.snow} + 25'(s1_ff.precip);
      c2_in.wv       = s1_ff.wv;
      c2_in.frozen   = s1_ff.temp[15] || (s1_ff.temp == 16'sd0);
      c2_in.precip   = s1_ff.precip;
      c2_in.pet      = s1_ff.pet;
      c2_in.snow     = s1_ff.snow;
      c2_in.up       = s1_ff.up;
      c2_in.low      = s1_ff.low;
      c2_in.cap0     = (ucap_ff < s1_ff.total) ? ucap_ff : s1_ff.total;
      c2_in.cap1     = s1_ff.total - c2_in.cap0;
      // saturate accumulation at the top of the snow range
      c2_in.snow_acc = snow_sum[24] ? '1 : snow_sum[23:0];
      melt_fac       = 23'(MELT_BASE) + 23'(s1_ff.precip) * 23'(MELT_GAIN);
      prod_in        = 38'(s1_ff.temp[14:0]) * 38'(melt_fac);
   end

   always_ff @(posedge clock) begin
      c2_ff   <= c2_in;
      prod_ff <= prod_in;
   end

   // ---------------------------------------------------------------------
   // Stage 3: divide by 1024 (shift), then by 50 through a reciprocal
   // ---------------------------------------------------------------------
   logic [37:0] rsum;
   logic [27:0] v_in, v_ff;
   logic [56:0] qe_full;
   logic [22:0] qe_ff;

   assign rsum    = prod_ff + 38'(MELT_ROUND);
   assign v_in    = rsum[37:10];
   assign qe_full = 57'(v_in) * 57'(RECIP_DIV);

   always_ff @(posedge clock) begin
      c3_ff <= c2_ff;
      v_ff  <= v_in;
      qe_ff <= qe_full[56:RECIP_SHIFT];
   end

   // ---------------------------------------------------------------------
   // Stage 4: correct the quotient by one, update the snow pack
   // ---------------------------------------------------------------------
   logic [27:0] rem;
   logic [22:0] melt;
   logic [23:0] snow_new_in, snow_new_ff;

   always_comb begin
      rem  = v_ff - 28'(qe_ff) * 28'(DIV_REST);
      melt = (rem >= 28'(DIV_REST)) ? qe_ff + 23'd1 : qe_ff;
      if (c3_ff.frozen) begin
         snow_new_in = c3_ff.snow_acc;
      end else if (24'(melt) >= c3_ff.snow) begin
         // melt beyond the pack empties it; an empty pack stays empty
         snow_new_in = '0;
      end else begin
         snow_new_in = c3_ff.snow - 24'(melt);
      end
   end

   always_ff @(posedge clock) begin
      c4_ff       <= c3_ff;
      snow_new_ff <= snow_new_in;
   end

   // ---------------------------------------------------------------------
   // Stage 5: upper layer balance, overflow to the lower layer
   // ---------------------------------------------------------------------
   logic signed [26:0] upn, negu;
   logic [23:0]        melt_amt;
   logic               over;
   logic [26:0]        dsw;
   logic [26:0]        low_sum;
   pay_type            w5_in, w5_ff;

   always_comb begin
      melt_amt = c4_ff.snow - snow_new_ff;
      upn = $signed({7'b0, c4_ff.up}) + $signed({9'b0, c4_ff.precip})
          + $signed({3'b0, melt_amt});
      // evaporation only once the pack is gone
      if (snow_new_ff == 24'd0) upn = upn - $signed({13'b0, c4_ff.pet});
      negu    = -upn;
      over    = upn > $signed({7'b0, c4_ff.cap0});
      dsw     = over ? 27'(upn - $signed({7'b0, c4_ff.cap0})) : '0;
      low_sum = 27'(c4_ff.low) + dsw;

      w5_in.wv       = c4_ff.wv;
      w5_in.frozen   = c4_ff.frozen;
      w5_in.def      = !c4_ff.frozen && upn[26];
      w5_in.snow_new = snow_new_ff;
      w5_in.snow_chg = $signed({1'b0, snow_new_ff}) - $signed({1'b0, c4_ff.snow});
      w5_in.low      = c4_ff.low;
      w5_in.cap1     = c4_ff.cap1;
      w5_in.deficit  = negu[13:0];
      w5_in.low_nd   = (low_sum > 27'(c4_ff.cap1)) ? c4_ff.cap1 : low_sum[19:0];
      if (c4_ff.frozen) begin
         w5_in.up_fin = c4_ff.up;
      end else if (over) begin
         w5_in.up_fin = c4_ff.cap0;
      end else if (upn[26]) begin
         w5_in.up_fin = '0;
      end else begin
         w5_in.up_fin = upn[19:0];
      end
   end

   always_ff @(posedge clock) begin
      w5_ff <= w5_in;
   end

   // Hold the payload alongside the draw pipeline
   pay_type dl_ff [1:DRAW_DLY];

   always_ff @(posedge clock) begin
      dl_ff[1] <= w5_ff;
      for (int i = 2; i <= DRAW_DLY; i++) begin
         dl_ff[i] <= dl_ff[i-1];
      end
   end

   // ---------------------------------------------------------------------
   // Lower layer draw: deficit * (lower / cap1) ^ r
   // ---------------------------------------------------------------------
   logic [19:0] n_low, n_cap;
   logic [20:0] lg_low, lg_cap;

   // zero operands take a dummy of one; those beats never use the draw
   assign n_low = (w5_ff.low == 20'd0) ? 20'd1 : w5_ff.low;
   assign n_cap = (w5_ff.cap1 == 20'd0) ? 20'd1 : w5_ff.cap1;

   sasw_log2 u_log_low (.clock(clock), .n(n_low), .lg(lg_low));
   sasw_log2 u_log_cap (.clock(clock), .n(n_cap), .lg(lg_cap));

   logic signed [21:0] lq;
   logic signed [34:0] rp_in, rp_ff;

   assign lq    = $signed({1'b0, lg_low}) - $signed({1'b0, lg_cap});
   assign rp_in = 35'($signed({1'b0, rexp_ff})) * 35'(lq);

   always_ff @(posedge clock) begin
      rp_ff <= rp_in;
   end

   // Round the exponent to Q16, split into integer and fraction
   logic [34:0]        rp_abs, rp_rnd;
   logic [26:0]        mag;
   logic signed [27:0] ex;
   logic signed [11:0] k;
   logic signed [11:0] sh_full;
   logic [15:0]        ef_ff;
   exp_side_type       side_in, side_ff, side_m;

   always_comb begin
      rp_abs       = rp_ff[34] ? 35'(-rp_ff) : 35'(rp_ff);
      rp_rnd       = rp_abs + 35'd128;
      mag          = rp_rnd[34:8];
      ex           = rp_ff[34] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
      k            = ex[27:16];
      sh_full      = 12'sd30 - k;
      side_in.sat  = k > 12'(K_SAT_MAX);
      side_in.zero = k < 12'(K_ZERO_MIN);
      side_in.sh   = sh_full[5:0];
   end

   always_ff @(posedge clock) begin
      ef_ff   <= ex[15:0];
      side_ff <= side_in;
   end

   logic [30:0] m;

   sasw_exp2 u_exp (
      .clock   (clock),
      .f       (ef_ff),
      .side_in (side_ff),
      .m       (m),
      .side_out(side_m)
   );

   logic [44:0]  p_ff;
   exp_side_type side_p_ff;

   always_ff @(posedge clock) begin
      p_ff      <= 45'(dl_ff[DRAW_TAP].deficit) * 45'(m);
      side_p_ff <= side_m;
   end

   // Scale by 2^k with round half up; a huge exponent empties the layer
   logic [45:0] half, psum, pshift;
   logic [35:0] draw_in, draw_ff;

   always_comb begin
      half   = 46'd1 << (side_p_ff.sh - 6'd1);
      psum   = {1'b0, p_ff} + half;
      pshift = psum >> side_p_ff.sh;
      if (side_p_ff.sat) begin
         draw_in = 36'd1 << 24;
      end else if (side_p_ff.zero) begin
         draw_in = '0;
      end else begin
         draw_in = pshift[35:0];
      end
   end

   always_ff @(posedge clock) begin
      draw_ff <= draw_in;
   end

   // ---------------------------------------------------------------------
   // Output stage: finish the lower layer, drop no-data beats to zero
   // ---------------------------------------------------------------------
   pay_type     fin;
   logic [35:0] drawv;
   logic [19:0] low_def, low_out;

   logic               o_nodata_ff, o_frozen_ff;
   logic [23:0]        o_snow_ff;
   logic [19:0]        o_up_ff, o_low_ff;
   logic signed [24:0] o_chg_ff;

   always_comb begin
      fin = dl_ff[DRAW_DLY];
      if (fin.cap1 == 20'd0) begin
         drawv = '0;
      end else if (rexp_ff == 12'd0) begin
         drawv = 36'(fin.deficit);
      end else if (fin.low == 20'd0) begin
         drawv = '0;
      end else begin
         drawv = draw_ff;
      end
      low_def = (drawv >= 36'(fin.low)) ? 20'd0 : fin.low - drawv[19:0];
      if (low_def > fin.cap1) low_def = fin.cap1;
      if (fin.frozen) begin
         low_out = fin.low;
      end else if (fin.def) begin
         low_out = low_def;
      end else begin
         low_out = fin.low_nd;
      end
   end

   always_ff @(posedge clock) begin
      o_nodata_ff <= !fin.wv;
      o_frozen_ff <= fin.frozen;
      o_snow_ff   <= fin.wv ? fin.snow_new : '0;
      o_up_ff     <= fin.wv ? fin.up_fin : '0;
      o_low_ff    <= fin.wv ? low_out : '0;
      o_chg_ff    <= fin.wv ? fin.snow_chg : '0;
   end

   assign rsp_valid           = out_vld_ff;
   assign rsp_cell_nodata     = o_nodata_ff;
   assign rsp_snow_out        = o_snow_ff;
   assign rsp_upper_water_out = o_up_ff;
   assign rsp_lower_water_out = o_low_ff;
   assign rsp_snow_change     = o_chg_ff;

`ifndef NO_ASSERTIONS
   // No-data beats carry only zeros
   a_nodata_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_cell_nodata |->
         rsp_snow_out == 24'd0 && rsp_upper_water_out == 20'd0 &&
         rsp_lower_water_out == 20'd0 && rsp_snow_change == 25'sd0)
      else $error("no-data beat with nonzero fields");

   // A frozen day never shrinks the pack
   a_frozen_accum: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_cell_nodata && o_frozen_ff |-> !rsp_snow_change[24])
      else $error("snow lost on a frozen day");

   // A thawing day never grows the pack
   a_thaw_melt: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_cell_nodata && !o_frozen_ff |->
         rsp_snow_change[24] || rsp_snow_change == 25'sd0)
      else $error("snow gained on a thawing day");
`endif

endmodule
